@@ sv/dynamic_smoothing_filter_defines.svh @@
// ----------------------------------------------------------------------------
// Dynamic smoothing filter assertion macros
// ----------------------------------------------------------------------------
// Concurrent assertion wrappers clocked on i_clk and disabled during reset.
// Defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_SMOOTHING_FILTER_DEFINES_SVH
`define DYNAMIC_SMOOTHING_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DSF_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);
`else
`define DSF_ASSERT(label, prop, msg)
`define DSF_ASSERT_IMPLY(label, cond, prop, msg)
`endif

`endif

@@ sv/dsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Dynamic smoothing filter package
// ----------------------------------------------------------------------------
// Widths, fixed-point constants and the types shared between the front end,
// the item queue, the datapath and the top level.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int VALUE_WIDTH = 24;
    localparam int BLOCK_MAX   = 1024;

    // Fixed input field widths.
    localparam int CMD_W  = 2;
    localparam int LEN_W  = 11;
    localparam int N_W    = $clog2(BLOCK_MAX + 1);

    // Configuration registers.
    localparam int CUTOFF_W   = 17;
    localparam int SENS_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 17'd1311;
    localparam logic [SENS_W-1:0]   SENS_RESET   = '0;

    // Gain is unsigned Q1.17, cutoff Q0.18, polynomial coefficients Q.24.
    localparam int GAIN_W   = 18;
    localparam int GAIN_ONE = 131072;
    localparam int WC_MAX   = 131071;
    localparam int POLY_A   = 267631190;
    localparam int POLY_B   = 200811464;
    localparam int POLY_C   = 100577442;

    // Shared multiplier operand widths (signed).
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = ((VALUE_WIDTH + 1) > (N_W + 1))
                             ? (((VALUE_WIDTH + 1) > (CUTOFF_W + 1)) ? VALUE_WIDTH + 1
                                                                     : CUTOFF_W + 1)
                             : (((N_W + 1) > (CUTOFF_W + 1)) ? N_W + 1 : CUTOFF_W + 1);

    // Item queue between front end and datapath; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_RUN,
        KIND_FORCE,
        KIND_REPORT
    } t_kind;

    typedef struct packed {
        t_kind                          kind;
        logic                           use_held;
        logic signed [VALUE_WIDTH-1:0]  value;
        logic [N_W-1:0]                 len;
    } t_item;

    typedef struct packed {
        logic [CUTOFF_W-1:0] cutoff;
        logic [SENS_W-1:0]   sens;
    } t_cfg;

endpackage

@@ sv/dsf_front.sv @@
// ----------------------------------------------------------------------------
// Dynamic smoothing filter front end
// ----------------------------------------------------------------------------
// Accepts input transactions, decodes the command into an item kind and
// saturates the block length to the range 1 to BLOCK_MAX, then holds the
// classified item in a register until the queue takes it.
// ----------------------------------------------------------------------------
module dsf_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [dsf_pkg::CMD_W-1:0]              i_command,
    input  logic signed [dsf_pkg::VALUE_WIDTH-1:0] i_sample_value,
    input  logic [dsf_pkg::LEN_W-1:0]              i_block_length,
    output logic                                   o_item_valid,
    input  logic                                   i_item_ready,
    output dsf_pkg::t_item                         o_item
);
    import dsf_pkg::*;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILTER = 2'd0,
        CMD_SKIP   = 2'd1,
        CMD_FORCE  = 2'd2
    } t_command;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.value    = i_sample_value;
        n_item.use_held = 1'b0;
        case (t_command'(i_command))
            CMD_FILTER: begin
                n_item.kind = KIND_RUN;
            end
            CMD_SKIP: begin
                n_item.kind     = KIND_RUN;
                n_item.use_held = 1'b1;
            end
            CMD_FORCE: begin
                n_item.kind = KIND_FORCE;
            end
            default: begin
                n_item.kind = KIND_REPORT;
            end
        endcase

        // A zero length counts as one sample.
        if (i_block_length == '0) begin
            n_item.len = N_W'(1);
        end else if (32'(i_block_length) > 32'(BLOCK_MAX)) begin
            n_item.len = N_W'(BLOCK_MAX);
        end else begin
            n_item.len = N_W'(i_block_length);
        end
    end

    assign o_ready      = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

@@ sv/dsf_queue.sv @@
// ----------------------------------------------------------------------------
// Dynamic smoothing filter item queue
// ----------------------------------------------------------------------------
// Small register FIFO that decouples the front end from the datapath.
// ----------------------------------------------------------------------------
`include "dynamic_smoothing_filter_defines.svh"

module dsf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  dsf_pkg::t_item i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output dsf_pkg::t_item o_pop_item
);
    import dsf_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != Q_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Pointers wrap on their own since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10: begin
                    r_count <= r_count + 1'b1;
                end
                2'b01: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    `DSF_ASSERT(a_count_step, (w_push && !w_pop) |=> (r_count == Q_CNT_W'($past(r_count) + 1'b1)), "queue count did not follow a push")
    `DSF_ASSERT_IMPLY(a_ptr_align, (r_count == '0) || (r_count == Q_CNT_W'(QUEUE_DEPTH)), r_wr_ptr == r_rd_ptr, "queue pointers out of step with count")

endmodule

@@ sv/dsf_back.sv @@
// ----------------------------------------------------------------------------
// Dynamic smoothing filter datapath
// ----------------------------------------------------------------------------
// Executes one queued item at a time. A step sequencer drives a single shared
// signed multiplier through the cutoff polynomial, the sensitivity term, and
// the two one-pole stage updates, then hands the result to an output register.
// ----------------------------------------------------------------------------
`include "dynamic_smoothing_filter_defines.svh"

module dsf_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dsf_pkg::t_cfg                          i_cfg,
    input  logic                                   i_item_valid,
    output logic                                   o_item_ready,
    input  dsf_pkg::t_item                         i_item,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [dsf_pkg::VALUE_WIDTH-1:0] o_smoothed_value,
    output logic signed [dsf_pkg::VALUE_WIDTH-1:0] o_target_value
);
    import dsf_pkg::*;

    localparam int VW          = VALUE_WIDTH;
    localparam int DIFF_W      = VW + 1;
    localparam int MP_W        = MUL_A_W + MUL_B_W;
    localparam int SN_W        = SENS_W + N_W;
    localparam int SN_LO_W     = (SN_W + 1) / 2;
    localparam int ACC_W       = SN_W + VW;
    localparam int TERM_SH     = VW - 3;
    localparam int TERM_W      = ACC_W - TERM_SH;
    localparam int POLY_W      = 31;
    localparam int POLY_SH     = 18;
    localparam int G0_SH       = 7;
    localparam int G0_W        = 20;
    localparam int STAGE_SH    = 17;
    localparam logic signed [MP_W-1:0] POLY_HALF  = MP_W'(2 ** (POLY_SH - 1));
    localparam logic signed [MP_W-1:0] G0_HALF    = MP_W'(2 ** (G0_SH - 1));
    localparam logic signed [MP_W-1:0] STAGE_HALF = MP_W'(2 ** (STAGE_SH - 1));

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Each step names the multiply it launches or the result it settles.
    typedef enum logic [3:0] {
        ST_CUT_N,
        ST_SENS_N,
        ST_POLY1,
        ST_TERM_LO,
        ST_POLY2,
        ST_TERM_HI,
        ST_POLY3,
        ST_PARTS,
        ST_GAIN,
        ST_MUL1,
        ST_ADD1,
        ST_DIFF2,
        ST_MUL2,
        ST_ADD2
    } t_step;

    t_state                    r_state;
    t_step                     r_step;
    logic signed [VW-1:0]      r_first;
    logic signed [VW-1:0]      r_second;
    logic signed [VW-1:0]      r_target;
    logic signed [VW-1:0]      r_x;
    logic signed [DIFF_W-1:0]  r_diff;
    logic [VW-1:0]             r_mag;
    logic [N_W-1:0]            r_n;
    logic [CUTOFF_W-1:0]       r_wc;
    logic [SN_W-1:0]           r_sensn;
    logic [ACC_W-1:0]          r_acc;
    logic signed [POLY_W-1:0]  r_poly;
    logic [G0_W-1:0]           r_g0;
    logic [GAIN_W-1:0]         r_term;
    logic [GAIN_W-1:0]         r_gain;
    logic signed [MP_W-1:0]    r_prod;
    logic                      r_out_valid;
    logic signed [VW-1:0]      r_out_smoothed;
    logic signed [VW-1:0]      r_out_target;

    logic                      w_pop;
    logic                      w_out_free;
    logic                      w_out_load;
    logic signed [VW-1:0]      w_x;
    logic signed [DIFF_W-1:0]  w_band;
    logic [VW-1:0]             w_mag;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MP_W-1:0]    w_prod;
    logic [CUTOFF_W-1:0]       w_wc_sat;
    logic signed [MP_W-1:0]    w_rnd_poly;
    logic signed [MP_W-1:0]    w_g0_full;
    logic [TERM_W-1:0]         w_term_hi;
    logic [GAIN_W-1:0]         w_term_sat;
    logic [G0_W:0]             w_gain_sum;
    logic [GAIN_W-1:0]         w_gain_sat;
    logic signed [MP_W-1:0]    w_stage_delta;
    logic signed [DIFF_W-1:0]  w_rem;

    assign o_item_ready = (r_state == S_IDLE);
    assign w_pop        = i_item_valid && o_item_ready;
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_out_load   = (r_state == S_DONE) && w_out_free;

    assign w_x    = i_item.use_held ? r_target : i_item.value;
    assign w_band = DIFF_W'(r_first) - DIFF_W'(r_second);
    assign w_mag  = w_band[DIFF_W-1] ? VW'(-w_band) : VW'(w_band);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_step)
            ST_CUT_N: begin
                w_mul_a = signed'(MUL_A_W'(i_cfg.cutoff));
                w_mul_b = signed'(MUL_B_W'(r_n));
            end
            ST_SENS_N: begin
                w_mul_a = signed'(MUL_A_W'(i_cfg.sens));
                w_mul_b = signed'(MUL_B_W'(r_n));
            end
            ST_POLY1: begin
                w_mul_a = MUL_A_W'(POLY_A);
                w_mul_b = signed'(MUL_B_W'(r_wc));
            end
            ST_TERM_LO: begin
                w_mul_a = signed'(MUL_A_W'(r_sensn[SN_LO_W-1:0]));
                w_mul_b = signed'(MUL_B_W'(r_mag));
            end
            ST_POLY2, ST_POLY3: begin
                w_mul_a = MUL_A_W'(r_poly);
                w_mul_b = signed'(MUL_B_W'(r_wc));
            end
            ST_TERM_HI: begin
                w_mul_a = signed'(MUL_A_W'(r_sensn[SN_W-1:SN_LO_W]));
                w_mul_b = signed'(MUL_B_W'(r_mag));
            end
            ST_MUL1, ST_MUL2: begin
                w_mul_a = signed'(MUL_A_W'(r_gain));
                w_mul_b = MUL_B_W'(r_diff);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = MP_W'(w_mul_a) * MP_W'(w_mul_b);

    // These shifts round half up, which is an arithmetic shift after adding half.
    assign w_wc_sat      = (r_prod > MP_W'(WC_MAX)) ? CUTOFF_W'(WC_MAX)
                                                    : r_prod[CUTOFF_W-1:0];
    assign w_rnd_poly    = (r_prod + POLY_HALF) >>> POLY_SH;
    assign w_g0_full     = (w_rnd_poly + G0_HALF) >>> G0_SH;
    assign w_stage_delta = (r_prod + STAGE_HALF) >>> STAGE_SH;

    // A product above one gain unit in the sensitivity term saturates to one.
    assign w_term_hi  = r_acc[ACC_W-1:TERM_SH];
    assign w_term_sat = (w_term_hi > TERM_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE)
                                                        : GAIN_W'(w_term_hi);
    assign w_gain_sum = (G0_W + 1)'(r_g0) + (G0_W + 1)'(r_term);
    assign w_gain_sat = (w_gain_sum > (G0_W + 1)'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE)
                                                             : GAIN_W'(w_gain_sum);
    assign w_rem      = DIFF_W'(r_x) - DIFF_W'(r_first);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_CUT_N;
            r_first     <= '0;
            r_second    <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        case (i_item.kind)
                            KIND_RUN: begin
                                if (!i_item.use_held) begin
                                    r_target <= i_item.value;
                                end
                                r_x     <= w_x;
                                r_n     <= i_item.len;
                                r_mag   <= w_mag;
                                r_step  <= ST_CUT_N;
                                r_state <= S_RUN;
                            end
                            KIND_FORCE: begin
                                r_first  <= i_item.value;
                                r_second <= i_item.value;
                                r_target <= i_item.value;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_prod <= w_prod;
                    if (r_step != ST_ADD2) begin
                        r_step <= t_step'(r_step + 4'd1);
                    end
                    case (r_step)
                        ST_SENS_N: begin
                            r_wc <= w_wc_sat;
                        end
                        ST_POLY1: begin
                            r_sensn <= SN_W'(r_prod);
                        end
                        ST_TERM_LO: begin
                            r_poly <= POLY_W'(w_rnd_poly - MP_W'(POLY_B));
                        end
                        ST_POLY2: begin
                            r_acc <= ACC_W'(r_prod);
                        end
                        ST_TERM_HI: begin
                            r_poly <= POLY_W'(w_rnd_poly + MP_W'(POLY_C));
                        end
                        ST_POLY3: begin
                            r_acc <= r_acc + (ACC_W'(r_prod) << SN_LO_W);
                        end
                        ST_PARTS: begin
                            r_g0   <= G0_W'(w_g0_full);
                            r_term <= w_term_sat;
                        end
                        ST_GAIN: begin
                            r_gain <= w_gain_sat;
                            r_diff <= DIFF_W'(r_x) - DIFF_W'(r_first);
                        end
                        ST_ADD1: begin
                            r_first <= r_first + VW'(w_stage_delta);
                        end
                        ST_DIFF2: begin
                            r_diff <= DIFF_W'(r_first) - DIFF_W'(r_second);
                        end
                        ST_ADD2: begin
                            r_second <= r_second + VW'(w_stage_delta);
                            r_state  <= S_DONE;
                        end
                        default: begin
                            // Multiply-only steps settle nothing here.
                        end
                    endcase
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_smoothed <= r_second;
                        r_out_target   <= r_target;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_smoothed_value = r_out_smoothed;
    assign o_target_value   = r_out_target;

    `DSF_ASSERT_IMPLY(a_gain_limit, (r_state == S_RUN) && (r_step == ST_MUL1), r_gain <= GAIN_W'(GAIN_ONE), "shared gain above one")
    `DSF_ASSERT_IMPLY(a_no_overshoot, (r_state == S_RUN) && (r_step == ST_DIFF2), !(((r_diff > 0) && (w_rem < 0)) || ((r_diff < 0) && (w_rem > 0))), "first stage passed its input")
    `DSF_ASSERT(a_force_load, (w_pop && (i_item.kind == KIND_FORCE)) |=> ((r_first == r_second) && (r_target == r_first)), "force did not load both stages")

endmodule

@@ sv/dynamic_smoothing_filter.sv @@
// ----------------------------------------------------------------------------
// Dynamic smoothing filter
// ----------------------------------------------------------------------------
// Adaptive two-pole low-pass smoother: two cascaded one-pole stages share a
// gain built from a cubic of the cutoff plus sensitivity times the stage
// difference, clamped to one.
//
// Channel   Handshake              Payload
// input     i_valid / o_ready      i_command, i_sample_value, i_block_length
// result    o_valid / i_ready      o_smoothed_value, o_target_value
// config    i_cfg_we, no wait      i_cfg_index, i_cfg_data
//
// A filter or skip transaction is picked from the queue, runs 14 steps on the
// one shared 31x25 multiplier and is then handed to the output register.
// Force and the unused code go from the pick straight to the handoff.
// The front end keeps taking transactions while the two-entry queue has room.
// Reset is synchronous; it zeroes both stages and the target and loads the
// register defaults. A stalled result holds the datapath in its done state.
// ----------------------------------------------------------------------------
module dynamic_smoothing_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [dsf_pkg::CMD_W-1:0]              i_command,
    input  logic signed [dsf_pkg::VALUE_WIDTH-1:0] i_sample_value,
    input  logic [dsf_pkg::LEN_W-1:0]              i_block_length,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [dsf_pkg::VALUE_WIDTH-1:0] o_smoothed_value,
    output logic signed [dsf_pkg::VALUE_WIDTH-1:0] o_target_value,
    input  logic                                   i_cfg_we,
    input  logic [dsf_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [dsf_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import dsf_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUTOFF = 1'b0,
        REG_SENS   = 1'b1
    } t_reg_index;

    t_cfg  r_cfg;
    logic  w_front_valid;
    logic  w_front_ready;
    t_item w_front_item;
    logic  w_queue_valid;
    logic  w_queue_ready;
    t_item w_queue_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cutoff <= CUTOFF_RESET;
            r_cfg.sens   <= SENS_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_CUTOFF: begin
                    r_cfg.cutoff <= i_cfg_data[CUTOFF_W-1:0];
                end
                REG_SENS: begin
                    r_cfg.sens <= i_cfg_data[SENS_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    dsf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_sample_value (i_sample_value),
        .i_block_length (i_block_length),
        .o_item_valid   (w_front_valid),
        .i_item_ready   (w_front_ready),
        .o_item         (w_front_item)
    );

    dsf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_item  (w_front_item),
        .o_pop_valid  (w_queue_valid),
        .i_pop_ready  (w_queue_ready),
        .o_pop_item   (w_queue_item)
    );

    dsf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_item_valid     (w_queue_valid),
        .o_item_ready     (w_queue_ready),
        .i_item           (w_queue_item),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_smoothed_value (o_smoothed_value),
        .o_target_value   (o_target_value)
    );

endmodule

@@ tb/tb_dynamic_smoothing_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dynamic smoothing filter testbench
// ----------------------------------------------------------------------------
// Drives filter, skip, force and unused-code transactions through the input
// channel. Each accepted transaction is run through a fixed-point model of the
// two-stage smoother, and the predicted output is queued. Every result
// transaction is compared with the oldest prediction. Both channels idle at
// random. One test holds the result channel off long enough to fill the block.
// The configuration registers are changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb_dynamic_smoothing_filter;

    localparam int VW      = dsf_pkg::VALUE_WIDTH;
    localparam int LEN_W   = dsf_pkg::LEN_W;
    localparam int CFG_W   = dsf_pkg::CFG_DATA_W;
    localparam int CYCLE_LIMIT = 200000;

    // Fixed-point constants of the smoother.
    localparam longint GAIN_UNITY   = 131072;
    localparam longint CUTOFF_CEIL  = 131071;
    localparam longint BLOCK_CAP    = 1024;
    localparam longint POLY_A_Q24   = 267631190;
    localparam longint POLY_B_Q24   = 200811464;
    localparam longint POLY_C_Q24   = 100577442;
    localparam int     SENS_SHIFT   = VW - 3;
    localparam longint unsigned SENS_LIMIT = 64'd131072 << (VW - 3);

    localparam logic signed [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VALUE_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_FILTER = 2'd0,
        CMD_SKIP   = 2'd1,
        CMD_FORCE  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_command;

    typedef enum logic [dsf_pkg::CFG_IDX_W-1:0] {
        REG_CUTOFF = 1'b0,
        REG_SENS   = 1'b1
    } t_reg_index;

    typedef struct {
        logic signed [VW-1:0] smoothed;
        logic signed [VW-1:0] target;
    } t_smoother_out;

    logic                             i_clk          = 1'b0;
    logic                             i_rst_n        = 1'b0;
    logic                             i_valid        = 1'b0;
    logic                             o_ready;
    logic [dsf_pkg::CMD_W-1:0]        i_command      = '0;
    logic signed [VW-1:0]             i_sample_value = '0;
    logic [LEN_W-1:0]                 i_block_length = '0;
    logic                             o_valid;
    logic                             i_ready        = 1'b0;
    logic signed [VW-1:0]             o_smoothed_value;
    logic signed [VW-1:0]             o_target_value;
    logic                             i_cfg_we       = 1'b0;
    logic [dsf_pkg::CFG_IDX_W-1:0]    i_cfg_index    = '0;
    logic [CFG_W-1:0]                 i_cfg_data     = '0;

    // Model state and register copies.
    longint          first_q;
    longint          second_q;
    longint          target_q;
    longint unsigned cutoff_q;
    longint unsigned sens_q;

    t_smoother_out awaited_outputs[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    bit            src_idle_on    = 1'b1;
    bit            sink_idle_on   = 1'b1;
    bit            sink_hold      = 1'b0;

    dynamic_smoothing_filter DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_sample_value   (i_sample_value),
        .i_block_length   (i_block_length),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_smoothed_value (o_smoothed_value),
        .o_target_value   (o_target_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Rounds half up: arithmetic shift on a signed value floors.
    function automatic longint round_half_up(longint x, int unsigned s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint cubic_base_gain(longint unsigned n);
        longint unsigned w;
        longint          wc;
        longint          p;
        w = cutoff_q * n;
        if (w > CUTOFF_CEIL)
            w = CUTOFF_CEIL;
        wc = longint'(w);
        p = round_half_up(POLY_A_Q24 * wc, 18) - POLY_B_Q24;
        p = round_half_up(p * wc, 18) + POLY_C_Q24;
        p = round_half_up(p * wc, 18);
        return round_half_up(p, 7);
    endfunction

    function automatic void run_lowpass(longint x, longint unsigned n);
        longint          band;
        longint unsigned mag;
        longint unsigned sens_n;
        longint unsigned term;
        longint          g;
        band   = first_q - second_q;
        mag    = (band < 0) ? -band : band;
        sens_n = sens_q * n;
        // The product would overflow for large sensitivity; it saturates instead.
        if (mag != 0 && sens_n > SENS_LIMIT / mag)
            term = GAIN_UNITY;
        else
            term = (sens_n * mag) >> SENS_SHIFT;
        if (term > GAIN_UNITY)
            term = GAIN_UNITY;
        g = cubic_base_gain(n) + longint'(term);
        if (g > GAIN_UNITY)
            g = GAIN_UNITY;
        first_q  += round_half_up(g * (x - first_q), 17);
        second_q += round_half_up(g * (first_q - second_q), 17);
    endfunction

    function automatic t_smoother_out advance_stages(t_command cmd,
                                                     logic signed [VW-1:0] value,
                                                     logic [LEN_W-1:0] len);
        longint unsigned n;
        longint          x;
        t_smoother_out   res;
        x = value;
        n = len;
        if (n == 0)
            n = 1;
        if (n > BLOCK_CAP)
            n = BLOCK_CAP;
        case (cmd)
            CMD_FILTER: begin
                target_q = x;
                run_lowpass(x, n);
            end
            CMD_SKIP: begin
                run_lowpass(target_q, n);
            end
            CMD_FORCE: begin
                target_q = x;
                first_q  = x;
                second_q = x;
            end
            default: begin
            end
        endcase
        res.smoothed = second_q[VW-1:0];
        res.target   = target_q[VW-1:0];
        return res;
    endfunction

    // Result channel: checks each transaction and drives ready.
    always @(posedge i_clk) begin : result_check
        t_smoother_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_outputs.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: unexpected result, smoothed_value %0d target_value %0d",
                         $time, o_smoothed_value, o_target_value);
            end else begin
                want = awaited_outputs.pop_front();
                if (o_smoothed_value !== want.smoothed) begin
                    mismatch_count++;
                    $display("%0t ns: smoothed_value expected %0d, actual %0d",
                             $time, want.smoothed, o_smoothed_value);
                end
                if (o_target_value !== want.target) begin
                    mismatch_count++;
                    $display("%0t ns: target_value expected %0d, actual %0d",
                             $time, want.target, o_target_value);
                end
            end
        end
        if (sink_hold)
            i_ready <= 1'b0;
        else if (sink_idle_on && $urandom_range(0, 99) < 22)
            i_ready <= 1'b0;
        else
            i_ready <= 1'b1;
    end

    // Called right after a rising edge; returns at the edge that accepts the
    // transaction.
    task automatic send_item(t_command cmd, logic signed [VW-1:0] value,
                             logic [LEN_W-1:0] len);
        while (src_idle_on && $urandom_range(0, 99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_sample_value <= value;
        i_block_length <= len;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        awaited_outputs.push_back(advance_stages(cmd, value, len));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers on back-to-back edges; the block must be idle.
    task automatic load_settings(logic [CFG_W-1:0] cutoff_data,
                                 logic [CFG_W-1:0] sens_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_CUTOFF;
        i_cfg_data  <= cutoff_data;
        @(posedge i_clk);
        i_cfg_index <= REG_SENS;
        i_cfg_data  <= sens_data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cutoff_q = cutoff_data[dsf_pkg::CUTOFF_W-1:0];
        sens_q   = sens_data[dsf_pkg::SENS_W-1:0];
    endtask

    task automatic send_random_item();
        int                   r;
        t_command             cmd;
        logic signed [VW-1:0] value;
        logic [LEN_W-1:0]     len;
        r = $urandom_range(0, 99);
        if (r < 60)
            cmd = CMD_FILTER;
        else if (r < 82)
            cmd = CMD_SKIP;
        else if (r < 95)
            cmd = CMD_FORCE;
        else
            cmd = CMD_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 4)
            value = VALUE_MAX;
        else if (r < 8)
            value = VALUE_MIN;
        else if (r < 10)
            value = '0;
        else
            value = VW'($urandom());
        r = $urandom_range(0, 99);
        if (r < 70)
            len = LEN_W'($urandom_range(1, 8));
        else if (r < 85)
            len = LEN_W'($urandom_range(0, 2047));
        else if (r < 95)
            len = LEN_W'($urandom_range(9, 64));
        else
            len = LEN_W'(BLOCK_CAP);
        send_item(cmd, value, len);
    endtask

    task automatic test_defaults();
        send_item(CMD_FILTER, VALUE_MAX, 1);
        send_item(CMD_FILTER, VALUE_MIN, 1);
        send_item(CMD_FILTER, '0, 0);
        // Block length above the cap, and a cutoff product that saturates.
        send_item(CMD_SKIP, VALUE_MAX, 2047);
        send_item(CMD_SKIP, '0, 1025);
        send_item(CMD_FILTER, VALUE_MAX, 1024);
        send_item(CMD_FORCE, VALUE_MIN, 3);
        send_item(CMD_FORCE, VALUE_MAX, 1);
        send_item(CMD_UNUSED, VALUE_MIN, 5);
        send_item(CMD_SKIP, VALUE_MIN, 1);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // Full cutoff and sensitivity: the sensitivity product saturates.
        load_settings(CFG_W'(CUTOFF_CEIL), {CFG_W{1'b1}});
        send_item(CMD_FORCE, VALUE_MIN, 1);
        send_item(CMD_FILTER, VALUE_MAX, 1);
        send_item(CMD_FILTER, VALUE_MIN, 3);
        send_item(CMD_SKIP, '0, 1);
        wait_idle();
        load_settings(CFG_W'(1311), '0);
        send_item(CMD_FORCE, '0, 1);
        send_item(CMD_FILTER, VALUE_MAX, 1);
        wait_idle();
        // Zero cutoff: the gain comes from the stage difference only.
        load_settings('0, CFG_W'(24'h004000));
        send_item(CMD_FILTER, VALUE_MAX, 7);
        send_item(CMD_SKIP, '0, 2047);
        wait_idle();
        load_settings('0, '0);
        send_item(CMD_FILTER, VALUE_MIN, 1);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: load_settings(CFG_W'($urandom_range(1, 4000)),
                                 CFG_W'($urandom_range(0, 131072)));
                // Upper data bits beyond the cutoff width are random here.
                1: load_settings(CFG_W'($urandom()), CFG_W'($urandom()));
                2: load_settings(CFG_W'(1311), CFG_W'(24'h010000));
                3: load_settings(CFG_W'(1), '0);
                default: load_settings(CFG_W'(CUTOFF_CEIL),
                                       CFG_W'($urandom_range(0, 65535)));
            endcase
            src_idle_on  = (phase != 2);
            sink_idle_on <= (phase != 2);
            repeat (160) send_random_item();
            wait_idle();
        end
        src_idle_on  = 1'b1;
        sink_idle_on <= 1'b1;
    endtask

    task automatic test_backpressure();
        fork
            begin
                sink_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        join_none
        src_idle_on = 1'b0;
        repeat (24) send_random_item();
        src_idle_on = 1'b1;
        wait_idle();
    endtask

    initial begin
        first_q  = 0;
        second_q = 0;
        target_q = 0;
        cutoff_q = 1311;
        sens_q   = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
